### hw/rtl/cbd_pkg.sv
package cbd_pkg;

  localparam int unsigned LEN_W            = 32;
  localparam int unsigned ACC_W            = 64;
  localparam int unsigned LINE_LEN_W       = 13;
  localparam int unsigned SIZE_LINE_MAX    = 1024;
  localparam int unsigned TRAILER_LINE_MAX = 4096;
  localparam int unsigned STATUS_W         = 3;
  localparam int unsigned CFG_IDX_W        = 2;

  localparam logic [LEN_W-1:0] MAX_BODY_RST = LEN_W'(1048576);

  localparam logic [CFG_IDX_W-1:0] CFG_CHUNKED_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CONTENT_LENGTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_BODY       = 2'd2;

  localparam logic [STATUS_W-1:0] ST_MORE    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DONE    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BAD     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_LARGE   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_TRAILER = 3'd4;

  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_SP   = 8'h20;
  localparam logic [7:0] CH_TAB  = 8'h09;
  localparam logic [7:0] CH_SEMI = 8'h3B;

  typedef enum logic [2:0] {
    PH_LENGTH,
    PH_SIZE,
    PH_DATA,
    PH_CRLF,
    PH_TRAILER,
    PH_DONE,
    PH_ERROR
  } phase_e;

  typedef enum logic [1:0] {
    PE_NONE,
    PE_BAD,
    PE_LARGE
  } pend_e;

  typedef struct packed {
    logic semi;
    logic crpend;
    logic wspend;
    logic have;
    logic lastcr;
    logic firstcr;
  } line_flags_t;

  typedef struct packed {
    line_flags_t      flags;
    pend_e            pend;
    logic [ACC_W-1:0] accum;
  } size_st_t;

  // One character of the size string, before trimming
  function automatic size_st_t size_char(size_st_t s, logic [7:0] c);
    size_st_t   r;
    logic       is_hex;
    logic [3:0] h;
    r      = s;
    is_hex = 1'b0;
    h      = c[3:0];
    if (c >= 8'h30 && c <= 8'h39) begin
      is_hex = 1'b1;
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      is_hex = 1'b1;
      h      = c[3:0] + 4'd9;
    end
    if (!s.flags.semi) begin
      if (c == CH_SEMI) begin
        r.flags.semi = 1'b1;
      end else if (c == CH_SP || c == CH_TAB) begin
        r.flags.wspend = 1'b1;
      end else begin
        r.flags.have = 1'b1;
        if (s.pend == PE_NONE) begin
          if (s.flags.wspend || !is_hex) begin
            r.pend = PE_BAD;
          end else if (s.accum[ACC_W-1:ACC_W-4] != 4'd0) begin
            r.pend = PE_LARGE;
          end else begin
            r.accum = {s.accum[ACC_W-5:0], h};
          end
        end
      end
    end
    return r;
  endfunction

endpackage

### hw/rtl/cbd_in_if.sv
interface cbd_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] data_byte;

  modport source (output valid, output command, output data_byte, input ready);
  modport sink (input valid, input command, input data_byte, output ready);
endinterface

### hw/rtl/cbd_out_if.sv
interface cbd_out_if;
  logic                          valid;
  logic                          ready;
  logic                          byte_taken;
  logic                          payload_valid;
  logic [7:0]                    payload_byte;
  logic                          body_end;
  logic [cbd_pkg::STATUS_W-1:0]  status;

  modport source (
    output valid, output byte_taken, output payload_valid, output payload_byte,
    output body_end, output status, input ready
  );
  modport sink (
    input valid, input byte_taken, input payload_valid, input payload_byte,
    input body_end, input status, output ready
  );
endinterface

### hw/rtl/chunked_body_decoder_unit.sv
// HTTP/1.1 message body deframer, one body byte per item.
// body_i carries items of {command, data_byte}: command 0 is a body byte,
// command 1 restarts decoding and latches chunked_mode from configuration.
// result_o returns exactly one result item per input item: byte_taken,
// payload_valid/payload_byte (decoded body data), a body_end pulse and the
// sticky status (need more, complete, bad request, too large, trailer too long).
// Configuration is a write-only port (cfg_we_i, cfg_idx_i, cfg_data_i);
// content_length and max_body are used live, so write them only while idle.
// An accepted item passes through two register stages (input register, then
// result register) before its result is valid.
// Throughput: one item per cycle while the receiver is ready; the per-byte state
// update (parse state, counters and size accumulator) is computed combinationally.
// Reset: fixed length mode with zero length, so a body byte sent before any
// restart is not taken and reports completion with a body_end pulse.
// Receiver stall: the result register holds, the input register fills, and
// body_i.ready drops only once both are occupied.
module chunked_body_decoder_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  cbd_in_if.sink                          body_i,
  cbd_out_if.source                       result_o,
  input  logic                            cfg_we_i,
  input  logic [cbd_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [cbd_pkg::LEN_W-1:0]       cfg_data_i
);

  typedef struct packed {
    logic                         byte_taken;
    logic                         payload_valid;
    logic [7:0]                   payload_byte;
    logic                         body_end;
    logic [cbd_pkg::STATUS_W-1:0] status;
  } result_t;

  // configuration
  logic                        chunked_mode_q;
  logic [cbd_pkg::LEN_W-1:0]   content_length_q;
  logic [cbd_pkg::LEN_W-1:0]   max_body_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chunked_mode_q   <= 1'b0;
      content_length_q <= '0;
      max_body_q       <= cbd_pkg::MAX_BODY_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        cbd_pkg::CFG_CHUNKED_MODE:   chunked_mode_q   <= cfg_data_i[0];
        cbd_pkg::CFG_CONTENT_LENGTH: content_length_q <= cfg_data_i;
        cbd_pkg::CFG_MAX_BODY:       max_body_q       <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input register and result register handshake
  logic       in_vld_q;
  logic       in_cmd_q;
  logic [7:0] in_byte_q;
  logic       out_vld_q;
  result_t    out_q;
  result_t    res_d;
  logic       advance;
  logic       in_acc;

  assign advance      = in_vld_q && (!out_vld_q || result_o.ready);
  assign body_i.ready = !in_vld_q || advance;
  assign in_acc       = body_i.valid && body_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_acc) begin
        in_vld_q <= 1'b1;
      end else if (advance) begin
        in_vld_q <= 1'b0;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
      end else if (result_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_cmd_q  <= body_i.command;
      in_byte_q <= body_i.data_byte;
    end
    if (advance) begin
      out_q <= res_d;
    end
  end

  assign result_o.valid         = out_vld_q;
  assign result_o.byte_taken    = out_q.byte_taken;
  assign result_o.payload_valid = out_q.payload_valid;
  assign result_o.payload_byte  = out_q.payload_byte;
  assign result_o.body_end      = out_q.body_end;
  assign result_o.status        = out_q.status;

  // decoder state
  cbd_pkg::phase_e                 phase_q, phase_d;
  logic [cbd_pkg::LEN_W-1:0]       total_q, total_d;
  logic [cbd_pkg::LEN_W-1:0]       chunk_q, chunk_d;
  logic [cbd_pkg::ACC_W-1:0]       accum_q, accum_d;
  logic [cbd_pkg::LINE_LEN_W-1:0]  len_q, len_d;
  cbd_pkg::line_flags_t            flags_q, flags_d;
  cbd_pkg::pend_e                  pend_q, pend_d;
  logic                            ended_q, ended_d;
  logic [cbd_pkg::STATUS_W-1:0]    err_q, err_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= cbd_pkg::PH_LENGTH;
      total_q <= '0;
      chunk_q <= '0;
      accum_q <= '0;
      len_q   <= '0;
      flags_q <= '0;
      pend_q  <= cbd_pkg::PE_NONE;
      ended_q <= 1'b0;
      err_q   <= cbd_pkg::ST_MORE;
    end else if (advance) begin
      phase_q <= phase_d;
      total_q <= total_d;
      chunk_q <= chunk_d;
      accum_q <= accum_d;
      len_q   <= len_d;
      flags_q <= flags_d;
      pend_q  <= pend_d;
      ended_q <= ended_d;
      err_q   <= err_d;
    end
  end

  always_comb begin
    cbd_pkg::size_st_t              ss;
    logic [cbd_pkg::LINE_LEN_W-1:0] len_inc;
    logic [cbd_pkg::LEN_W-1:0]      total_inc;
    logic [cbd_pkg::LEN_W-1:0]      room;
    logic                           finish;

    phase_d   = phase_q;
    total_d   = total_q;
    chunk_d   = chunk_q;
    accum_d   = accum_q;
    len_d     = len_q;
    flags_d   = flags_q;
    pend_d    = pend_q;
    ended_d   = ended_q;
    err_d     = err_q;
    res_d     = '0;
    finish    = 1'b0;
    len_inc   = len_q + 1'b1;
    total_inc = total_q + 1'b1;
    room      = max_body_q - total_q;
    ss        = '{flags: flags_q, pend: pend_q, accum: accum_q};

    if (in_cmd_q) begin
      total_d = '0;
      chunk_d = '0;
      accum_d = '0;
      len_d   = '0;
      flags_d = '0;
      pend_d  = cbd_pkg::PE_NONE;
      ended_d = 1'b0;
      err_d   = cbd_pkg::ST_MORE;
      if (chunked_mode_q) begin
        phase_d = cbd_pkg::PH_SIZE;
      end else if (content_length_q > max_body_q) begin
        phase_d = cbd_pkg::PH_ERROR;
        err_d   = cbd_pkg::ST_LARGE;
      end else if (content_length_q == '0) begin
        finish = 1'b1;
      end else begin
        phase_d = cbd_pkg::PH_LENGTH;
      end
    end else begin
      unique case (phase_q)
        cbd_pkg::PH_LENGTH: begin
          if (total_q >= content_length_q) begin
            finish = 1'b1;
          end else begin
            res_d.byte_taken    = 1'b1;
            res_d.payload_valid = 1'b1;
            res_d.payload_byte  = in_byte_q;
            total_d             = total_inc;
            finish              = (total_inc == content_length_q);
          end
        end
        cbd_pkg::PH_SIZE: begin
          res_d.byte_taken = 1'b1;
          if (in_byte_q == cbd_pkg::CH_LF) begin
            // end of size line: first recorded error wins, then range check
            if (pend_q == cbd_pkg::PE_BAD || !flags_q.have) begin
              phase_d = cbd_pkg::PH_ERROR;
              err_d   = cbd_pkg::ST_BAD;
            end else if (pend_q == cbd_pkg::PE_LARGE || total_q > max_body_q ||
                         accum_q[cbd_pkg::ACC_W-1:cbd_pkg::LEN_W] != '0 ||
                         accum_q[cbd_pkg::LEN_W-1:0] > room) begin
              phase_d = cbd_pkg::PH_ERROR;
              err_d   = cbd_pkg::ST_LARGE;
            end else begin
              chunk_d = accum_q[cbd_pkg::LEN_W-1:0];
              accum_d = '0;
              len_d   = '0;
              flags_d = '0;
              pend_d  = cbd_pkg::PE_NONE;
              phase_d = (accum_q == '0) ? cbd_pkg::PH_TRAILER : cbd_pkg::PH_DATA;
            end
          end else if (len_inc > cbd_pkg::LINE_LEN_W'(cbd_pkg::SIZE_LINE_MAX)) begin
            phase_d = cbd_pkg::PH_ERROR;
            err_d   = cbd_pkg::ST_BAD;
          end else begin
            len_d = len_inc;
            // a CR not followed by LF counts as an ordinary character
            if (ss.flags.crpend) begin
              ss.flags.crpend = 1'b0;
              ss = cbd_pkg::size_char(ss, cbd_pkg::CH_CR);
            end
            if (in_byte_q == cbd_pkg::CH_CR) begin
              ss.flags.crpend = 1'b1;
            end else begin
              ss = cbd_pkg::size_char(ss, in_byte_q);
            end
            flags_d = ss.flags;
            pend_d  = ss.pend;
            accum_d = ss.accum;
          end
        end
        cbd_pkg::PH_DATA: begin
          res_d.byte_taken    = 1'b1;
          res_d.payload_valid = 1'b1;
          res_d.payload_byte  = in_byte_q;
          total_d             = total_inc;
          if (chunk_q != '0) begin
            chunk_d = chunk_q - 1'b1;
          end
          if (total_inc > max_body_q) begin
            phase_d = cbd_pkg::PH_ERROR;
            err_d   = cbd_pkg::ST_LARGE;
          end else if (chunk_q <= 1) begin
            accum_d = '0;
            len_d   = '0;
            flags_d = '0;
            pend_d  = cbd_pkg::PE_NONE;
            phase_d = cbd_pkg::PH_CRLF;
          end
        end
        cbd_pkg::PH_CRLF: begin
          res_d.byte_taken = 1'b1;
          len_d = len_inc;
          if (len_q == '0) begin
            if (in_byte_q == cbd_pkg::CH_LF) begin
              len_d   = '0;
              flags_d = '0;
              phase_d = cbd_pkg::PH_SIZE;
            end else if (in_byte_q == cbd_pkg::CH_CR) begin
              flags_d.firstcr = 1'b1;
            end
          end else if (flags_q.firstcr && in_byte_q == cbd_pkg::CH_LF) begin
            len_d   = '0;
            flags_d = '0;
            phase_d = cbd_pkg::PH_SIZE;
          end else begin
            phase_d = cbd_pkg::PH_ERROR;
            err_d   = cbd_pkg::ST_BAD;
          end
        end
        cbd_pkg::PH_TRAILER: begin
          res_d.byte_taken = 1'b1;
          if (in_byte_q == cbd_pkg::CH_LF) begin
            // an empty line, bare or CRLF, ends the body
            if (len_q == '0 || (len_q == 1 && flags_q.lastcr)) begin
              finish = 1'b1;
            end else begin
              len_d   = '0;
              flags_d = '0;
            end
          end else begin
            len_d          = len_inc;
            flags_d.lastcr = (in_byte_q == cbd_pkg::CH_CR);
            if (len_inc > cbd_pkg::LINE_LEN_W'(cbd_pkg::TRAILER_LINE_MAX)) begin
              phase_d = cbd_pkg::PH_ERROR;
              err_d   = cbd_pkg::ST_TRAILER;
            end
          end
        end
        default: ;
      endcase
    end

    if (finish) begin
      phase_d        = cbd_pkg::PH_DONE;
      ended_d        = 1'b1;
      res_d.body_end = in_cmd_q ? 1'b1 : !ended_q;
    end

    if (phase_d == cbd_pkg::PH_ERROR) begin
      res_d.status = err_d;
    end else if (phase_d == cbd_pkg::PH_DONE) begin
      res_d.status = cbd_pkg::ST_DONE;
    end else begin
      res_d.status = cbd_pkg::ST_MORE;
    end
  end

  // checks
  a_done_reported: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == cbd_pkg::PH_DONE |-> ended_q)
    else $error("done phase without reported end");

  a_data_has_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == cbd_pkg::PH_DATA |-> chunk_q != '0)
    else $error("data phase with empty chunk");

  a_end_is_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_q.body_end |-> out_q.status == cbd_pkg::ST_DONE)
    else $error("body_end without complete status");

  a_end_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && !in_cmd_q && ended_q |=> !out_q.body_end)
    else $error("body_end repeated without restart");

endmodule
